>>> src/asnf_pkg.sv
// Shared types and constants for the advertising scan name filter.
`timescale 1ns / 1ps
`default_nettype none

package asnf_pkg;

    localparam int BYTE_W    = 8;
    localparam int RSSI_W    = 8;
    localparam int ADDR_W    = 48;
    localparam int VERDICT_W = 3;
    localparam int MODE_W    = 2;
    localparam int REG_IDX_W = 3;
    localparam int NUM_STORED = 4;

    // Register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_MATCH_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RSSI_THRESHOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STORED_ADDR_0  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STORED_ADDR_1  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STORED_ADDR_2  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STORED_ADDR_3  = 3'd5;

    localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RESET = -8'sd70;

    // Bytes the name scanner looks for
    localparam logic [BYTE_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_TOKEN_0    = 8'h48;
    localparam logic [BYTE_W-1:0] CHAR_TOKEN_1    = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_TOKEN_2    = 8'h59;
    localparam logic [BYTE_W-1:0] AD_SHORT_NAME    = 8'h08;
    localparam logic [BYTE_W-1:0] AD_COMPLETE_NAME = 8'h09;

    typedef enum logic [MODE_W-1:0] {
        MODE_OPEN = 2'd0,
        MODE_ADDR = 2'd1,
        MODE_NAME = 2'd2,
        MODE_ALT_OPEN = 2'd3
    } mode_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_NONE          = 3'd0,
        V_NAME_MISMATCH = 3'd1,
        V_ADDR_FOUND    = 3'd2,
        V_ADDR_UNKNOWN  = 3'd3,
        V_RSSI_OK       = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        TK_SKIP  = 3'd0,
        TK_T0    = 3'd1,
        TK_T1    = 3'd2,
        TK_T2    = 3'd3,
        TK_MATCH = 3'd4,
        TK_FAIL  = 3'd5
    } token_t;

    typedef struct packed {
        mode_t                      mode;
        logic signed [RSSI_W-1:0]   rssi_threshold;
    } filter_cfg_t;

    typedef struct packed {
        logic     accept;
        verdict_t reason;
    } result_t;

endpackage

`default_nettype wire

>>> src/asnf_if.sv
// Valid/ready channel interfaces for advertising bytes and verdicts.
`timescale 1ns / 1ps
`default_nettype none

interface asnf_in_if;
    logic                              valid;
    logic                              ready;
    logic [asnf_pkg::BYTE_W-1:0]       adv_byte;
    logic                              last_byte;
    logic signed [asnf_pkg::RSSI_W-1:0] rssi;
    logic [asnf_pkg::ADDR_W-1:0]       peer_address;

    modport source (output valid, output adv_byte, output last_byte, output rssi,
                    output peer_address, input ready);
    modport sink   (input valid, input adv_byte, input last_byte, input rssi,
                    input peer_address, output ready);
endinterface

interface asnf_out_if;
    logic                              valid;
    logic                              ready;
    logic                              accept;
    logic [asnf_pkg::VERDICT_W-1:0]    verdict_reason;

    modport source (output valid, output accept, output verdict_reason, input ready);
    modport sink   (input valid, input accept, input verdict_reason, output ready);
endinterface

`default_nettype wire

>>> src/asnf_addr_match.sv
// Peer address lookup against the stored address registers.
`timescale 1ns / 1ps
`default_nettype none

module asnf_addr_match #(
    parameter int TABLE_ENTRIES = 4
) (
    input  wire logic [asnf_pkg::ADDR_W-1:0] peer_address,
    input  wire logic [asnf_pkg::ADDR_W-1:0] stored_addr [asnf_pkg::NUM_STORED],
    output logic                             found
);

    always_comb
    begin
        found = 1'b0;
        // Entries past the parameter are not searched
        for (int i = 0; i < asnf_pkg::NUM_STORED; i++)
        begin
            if (i < TABLE_ENTRIES && stored_addr[i] == peer_address)
            begin
                found = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/asnf_parser.sv
// Length/type structure walker, name token scanner and verdict logic.
`timescale 1ns / 1ps
`default_nettype none

module asnf_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               beat,
    input  wire logic [asnf_pkg::BYTE_W-1:0]        adv_byte,
    input  wire logic                               last_byte,
    input  wire logic signed [asnf_pkg::RSSI_W-1:0] rssi,
    input  wire logic                               addr_found,
    input  wire asnf_pkg::filter_cfg_t              cfg,
    output asnf_pkg::result_t                       result
);

    asnf_pkg::phase_t   phase_reg, phase_next;
    logic [asnf_pkg::BYTE_W-1:0] left_reg, left_next;
    logic               name_reg, name_next;
    asnf_pkg::token_t   tok_reg, tok_next;
    logic               dec_reg, dec_next;
    asnf_pkg::verdict_t held_reg, held_next;
    logic               end_struct;
    logic               matched;

    function automatic asnf_pkg::token_t feed_name(asnf_pkg::token_t s,
                                                   logic [asnf_pkg::BYTE_W-1:0] c);
        asnf_pkg::token_t r;
        r = s;
        if (s == asnf_pkg::TK_MATCH || s == asnf_pkg::TK_FAIL)
        begin
            r = s;
        end
        else if (c == asnf_pkg::CHAR_NUL || c == asnf_pkg::CHAR_UNDERSCORE)
        begin
            if (s == asnf_pkg::TK_T2)
                r = asnf_pkg::TK_MATCH;
            else if (s == asnf_pkg::TK_SKIP && c == asnf_pkg::CHAR_UNDERSCORE)
                r = asnf_pkg::TK_SKIP;
            else
                r = asnf_pkg::TK_FAIL;
        end
        else
        begin
            case (s)
                asnf_pkg::TK_SKIP:
                    r = (c == asnf_pkg::CHAR_TOKEN_0) ? asnf_pkg::TK_T0 : asnf_pkg::TK_FAIL;
                asnf_pkg::TK_T0:
                    r = (c == asnf_pkg::CHAR_TOKEN_1) ? asnf_pkg::TK_T1 : asnf_pkg::TK_FAIL;
                asnf_pkg::TK_T1:
                    r = (c == asnf_pkg::CHAR_TOKEN_2) ? asnf_pkg::TK_T2 : asnf_pkg::TK_FAIL;
                default:
                    r = asnf_pkg::TK_FAIL;
            endcase
        end
        return r;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        name_next  = name_reg;
        tok_next   = tok_reg;
        dec_next   = dec_reg;
        held_next  = held_reg;
        end_struct = 1'b0;
        matched    = 1'b0;

        if (beat && !dec_reg && phase_reg != asnf_pkg::PH_STOP)
        begin
            unique case (phase_reg)
                asnf_pkg::PH_LEN:
                begin
                    if (adv_byte == '0)
                    begin
                        phase_next = asnf_pkg::PH_STOP;
                    end
                    else
                    begin
                        left_next  = adv_byte - 8'd1;
                        phase_next = asnf_pkg::PH_TYPE;
                    end
                end
                asnf_pkg::PH_TYPE:
                begin
                    name_next = (adv_byte == asnf_pkg::AD_SHORT_NAME) ||
                                (adv_byte == asnf_pkg::AD_COMPLETE_NAME);
                    tok_next  = asnf_pkg::TK_SKIP;
                    if (left_reg == '0)
                        end_struct = 1'b1;
                    else
                        phase_next = asnf_pkg::PH_DATA;
                end
                asnf_pkg::PH_DATA:
                begin
                    if (name_reg)
                        tok_next = feed_name(tok_reg, adv_byte);
                    left_next = left_reg - 8'd1;
                    if (left_next == '0)
                        end_struct = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // Judge a name structure once its last data byte is in
            if (end_struct)
            begin
                phase_next = asnf_pkg::PH_LEN;
                if (name_next)
                begin
                    name_next = 1'b0;
                    matched = (tok_next == asnf_pkg::TK_T2) ||
                              (tok_next == asnf_pkg::TK_MATCH);
                    if (!matched)
                    begin
                        dec_next  = 1'b1;
                        held_next = asnf_pkg::V_NAME_MISMATCH;
                    end
                    else
                    begin
                        case (cfg.mode)
                            asnf_pkg::MODE_ADDR:
                            begin
                                dec_next  = 1'b1;
                                held_next = addr_found ? asnf_pkg::V_ADDR_FOUND
                                                       : asnf_pkg::V_ADDR_UNKNOWN;
                            end
                            asnf_pkg::MODE_NAME:
                            begin
                                if (rssi > cfg.rssi_threshold)
                                begin
                                    dec_next  = 1'b1;
                                    held_next = asnf_pkg::V_RSSI_OK;
                                end
                            end
                            default:
                            begin
                                dec_next = dec_reg;
                            end
                        endcase
                    end
                end
            end
        end

        result.accept = dec_next && (held_next == asnf_pkg::V_ADDR_FOUND ||
                                     held_next == asnf_pkg::V_RSSI_OK);
        result.reason = dec_next ? held_next : asnf_pkg::V_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= asnf_pkg::PH_LEN;
            left_reg  <= '0;
            name_reg  <= 1'b0;
            tok_reg   <= asnf_pkg::TK_SKIP;
            dec_reg   <= 1'b0;
            held_reg  <= asnf_pkg::V_NONE;
        end
        else if (beat && last_byte)
        begin
            // Start the next report clean
            phase_reg <= asnf_pkg::PH_LEN;
            left_reg  <= '0;
            name_reg  <= 1'b0;
            tok_reg   <= asnf_pkg::TK_SKIP;
            dec_reg   <= 1'b0;
            held_reg  <= asnf_pkg::V_NONE;
        end
        else if (beat)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            name_reg  <= name_next;
            tok_reg   <= tok_next;
            dec_reg   <= dec_next;
            held_reg  <= held_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        beat && last_byte |=> phase_reg == asnf_pkg::PH_LEN && !dec_reg && !name_reg)
        else $error("parse state not cleared after last beat");

    a_decision_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg && !(beat && last_byte) |=> dec_reg && held_reg == $past(held_reg))
        else $error("decision changed before end of report");

endmodule

`default_nettype wire

>>> src/adv_scan_name_filter_core.sv
// Top level of the advertising scan name filter: config registers and verdict register.
`timescale 1ns / 1ps
`default_nettype none

// Advertising scan name filter. Feed the advertising data of a report one byte per beat,
// with the report's RSSI and peer address on every beat; mark the final byte with
// last_byte. The block takes one byte every clock cycle when not stalled: each beat passes
// through a single parse-state update, and the verdict for a report leaves from an output
// register in the cycle after its last byte is taken. Only beats with last_byte produce a
// verdict. Input stalls only while a verdict waits in the output register and the sink
// holds ready low. Write the configuration registers only while no report is in progress.
module adv_scan_name_filter_core #(
    parameter int TABLE_ENTRIES = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    asnf_in_if.sink                                  adv,
    asnf_out_if.source                               verdict,
    input  wire logic                                wr_en,
    input  wire logic [asnf_pkg::REG_IDX_W-1:0]      wr_index,
    input  wire logic [asnf_pkg::ADDR_W-1:0]         wr_data
);

    asnf_pkg::filter_cfg_t           cfg_reg;
    logic [asnf_pkg::ADDR_W-1:0]     addr_reg [asnf_pkg::NUM_STORED];
    logic                            beat;
    logic                            addr_found;
    asnf_pkg::result_t               result;
    logic                            out_valid_reg;
    logic                            out_accept_reg;
    asnf_pkg::verdict_t              out_reason_reg;

    assign adv.ready = !out_valid_reg || verdict.ready;
    assign beat      = adv.valid && adv.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= asnf_pkg::MODE_OPEN;
            cfg_reg.rssi_threshold <= asnf_pkg::RSSI_THRESHOLD_RESET;
            for (int i = 0; i < asnf_pkg::NUM_STORED; i++)
            begin
                addr_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                asnf_pkg::REG_MATCH_MODE:
                    cfg_reg.mode <= asnf_pkg::mode_t'(wr_data[asnf_pkg::MODE_W-1:0]);
                asnf_pkg::REG_RSSI_THRESHOLD:
                    cfg_reg.rssi_threshold <= $signed(wr_data[asnf_pkg::RSSI_W-1:0]);
                asnf_pkg::REG_STORED_ADDR_0: addr_reg[0] <= wr_data;
                asnf_pkg::REG_STORED_ADDR_1: addr_reg[1] <= wr_data;
                asnf_pkg::REG_STORED_ADDR_2: addr_reg[2] <= wr_data;
                asnf_pkg::REG_STORED_ADDR_3: addr_reg[3] <= wr_data;
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    asnf_addr_match #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_addr_match (
        .peer_address (adv.peer_address),
        .stored_addr  (addr_reg),
        .found        (addr_found)
    );

    asnf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .adv_byte   (adv.adv_byte),
        .last_byte  (adv.last_byte),
        .rssi       (adv.rssi),
        .addr_found (addr_found),
        .cfg        (cfg_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat && adv.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the verdict payload until the next report ends
    always_ff @(posedge clk)
    begin
        if (beat && adv.last_byte)
        begin
            out_accept_reg <= result.accept;
            out_reason_reg <= result.reason;
        end
    end

    assign verdict.valid          = out_valid_reg;
    assign verdict.accept         = out_accept_reg;
    assign verdict.verdict_reason = out_reason_reg;

    a_verdict_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        beat && adv.last_byte |=> verdict.valid)
        else $error("no verdict after last beat");

    a_no_spurious_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        !verdict.valid && !(beat && adv.last_byte) |=> !verdict.valid)
        else $error("verdict without a last beat");

    a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid && verdict.accept |->
            (out_reason_reg == asnf_pkg::V_ADDR_FOUND ||
             out_reason_reg == asnf_pkg::V_RSSI_OK))
        else $error("accept with a rejecting reason");

endmodule

`default_nettype wire
